/* design/gbn_pkg.sv */
// gbn_pkg: shared types and codes of the go-back-n sender
// field widths, input operation codes, result action codes, register indexes
// no dependencies
package gbn_pkg;

	localparam int KIND_W    = 2;
	localparam int FSEQ_W    = 16;
	localparam int SLOT_W    = 5;
	localparam int ACTION_W  = 2;
	localparam int WSIZE_W   = 6;
	localparam int TOTAL_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;
	localparam int FLIGHT_W  = 6;

	typedef logic [FSEQ_W-1:0] fseq_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// raw kind field of an input transaction
	typedef enum logic [KIND_W-1:0] {
		KIND_SEND    = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_UNUSED  = 2'd3
	} kind_t;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SEND   = 2'd0,
		ACT_RESEND = 2'd1,
		ACT_ACK    = 2'd2,
		ACT_IGNORE = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_LIMIT    = 1'd0,
		REG_TOTAL_FRAMES = 1'd1
	} cfg_idx_t;

	typedef struct packed {
		op_t   op;
		fseq_t ack_seq;
	} item_t;

endpackage

/* design/gbn_if.sv */
// gbn_if: channel interfaces of the go-back-n sender
// request, result and configuration write channels; uses gbn_pkg
interface gbn_req_if;
	logic                        valid;
	logic                        ready;
	logic [gbn_pkg::KIND_W-1:0]  kind;
	logic [gbn_pkg::FSEQ_W-1:0]  ack_seq;

	modport source (output valid, output kind, output ack_seq, input ready);
	modport sink (input valid, input kind, input ack_seq, output ready);
endinterface

interface gbn_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gbn_pkg::ACTION_W-1:0]  action;
	logic [gbn_pkg::FSEQ_W-1:0]    frame_seq;
	logic [gbn_pkg::SLOT_W-1:0]    slot;
	logic                          all_acked;
	logic                          last;

	modport source (output valid, output action, output frame_seq, output slot,
		output all_acked, output last, input ready);
	modport sink (input valid, input action, input frame_seq, input slot,
		input all_acked, input last, output ready);
endinterface

interface gbn_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gbn_pkg::CFG_IDX_W-1:0]  index;
	logic [gbn_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/gbn_front.sv */
// gbn_front: input register stage that classifies each request transaction
// depends on gbn_pkg and gbn_req_if
module gbn_front (
	input  logic              clk,
	input  logic              arst_n,
	gbn_req_if.sink           req,
	output logic              push_valid,
	input  logic              push_ready,
	output gbn_pkg::item_t    push_item
);

	logic           valid_s1;
	gbn_pkg::item_t item_s1;
	gbn_pkg::op_t   op_dec;

	assign req.ready = !valid_s1 || push_ready;

	always_comb begin
		case (gbn_pkg::kind_t'(req.kind))
			gbn_pkg::KIND_SEND:    op_dec = gbn_pkg::OP_SEND;
			gbn_pkg::KIND_ACK:     op_dec = gbn_pkg::OP_ACK;
			gbn_pkg::KIND_TIMEOUT: op_dec = gbn_pkg::OP_TIMEOUT;
			default:               op_dec = gbn_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.op      <= op_dec;
			item_s1.ack_seq <= req.ack_seq;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

/* design/gbn_queue.sv */
// gbn_queue: two-entry queue of classified items between front and back
// depends on gbn_pkg
module gbn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  gbn_pkg::item_t    push_item,
	output logic              head_valid,
	input  logic              pop,
	output gbn_pkg::item_t    head_item
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	gbn_pkg::item_t         mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = count_q != (PTR_W + 1)'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* design/gbn_back.sv */
// gbn_back: window state, slot tracking and result generation
// depends on gbn_pkg and gbn_rsp_if
module gbn_back #(
	parameter int WINDOW_MAX = 32,
	parameter int SEQ_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  gbn_pkg::item_t                  head_item,
	output logic                            pop,
	input  logic [gbn_pkg::WSIZE_W-1:0]     win_limit,
	input  logic [gbn_pkg::TOTAL_W-1:0]     total_frames,
	input  logic                            win_wr,
	gbn_rsp_if.source                       rsp
);

	localparam int WB    = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (SEQ_BITS > gbn_pkg::TOTAL_W) ? SEQ_BITS : gbn_pkg::TOTAL_W;
	localparam int CNT_W = $clog2(SEQ_BITS + 1);
	localparam int FW7   = 7;
	localparam int FW    = gbn_pkg::FLIGHT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_REM  = 3'b010,
		ST_RUN  = 3'b100
	} back_state_t;

	typedef logic [SEQ_BITS-1:0] seq_t;
	typedef logic [WB-1:0]       wslot_t;

	back_state_t      state_q, nx_state;
	seq_t             next_seq_q, nx_next_seq;
	seq_t             oldest_q, nx_oldest;
	logic [FW-1:0]    in_flight_q, nx_in_flight;
	wslot_t           next_slot_q, nx_next_slot;
	wslot_t           old_slot_q, nx_old_slot;
	logic             stale_q, nx_stale;

	seq_t             run_seq_q, nx_run_seq;
	wslot_t           run_slot_q, nx_run_slot;
	logic [FW7-1:0]   run_left_q, nx_run_left;

	seq_t             rem_n_q, nx_rem_n;
	seq_t             rem_o_q, nx_rem_o;
	wslot_t           rem_rn_q, nx_rem_rn;
	wslot_t           rem_ro_q, nx_rem_ro;
	logic [CNT_W-1:0] rem_cnt_q, nx_rem_cnt;

	logic             out_valid_q;
	logic             out_free;
	logic             out_load;
	gbn_pkg::action_t o_action;
	seq_t             o_seq;
	wslot_t           o_slot;
	logic             o_last;
	logic             o_done;

	gbn_pkg::action_t out_action_q;
	gbn_pkg::fseq_t   out_seq_q;
	gbn_pkg::slot_t   out_slot_q;
	logic             out_done_q;
	logic             out_last_q;

	wslot_t           w;
	logic [FW7-1:0]   ws7;
	logic [FW7-1:0]   flight7;
	logic [FW7-1:0]   run_n;
	seq_t             ack_v;
	logic             can_send;

	// one restoring remainder step: shift in one bit, subtract window if it fits
	function automatic wslot_t rem_step(input wslot_t r, input logic b, input wslot_t wv);
		logic [WB:0] t;
		t = {r, b};
		if (t >= {1'b0, wv}) begin
			t = t - {1'b0, wv};
		end
		return t[WB-1:0];
	endfunction

	// slot of the following sequence, wrapping at the window; a wrapping sequence restarts at slot zero
	function automatic wslot_t slot_inc(input wslot_t s, input wslot_t wv, input logic wrap);
		logic [WB:0] t;
		t = {1'b0, s} + 1'b1;
		if (wrap || t == {1'b0, wv}) begin
			t = '0;
		end
		return t[WB-1:0];
	endfunction

	// effective window: saturate register to 1..WINDOW_MAX
	assign ws7 = FW7'(win_limit);
	always_comb begin
		if (win_limit == '0) begin
			w = WB'(1);
		end else if (ws7 > FW7'(WINDOW_MAX)) begin
			w = WB'(WINDOW_MAX);
		end else begin
			w = WB'(win_limit);
		end
	end

	assign flight7  = FW7'(in_flight_q);
	assign run_n    = (flight7 > FW7'(WINDOW_MAX)) ? FW7'(WINDOW_MAX) : flight7;
	assign ack_v    = SEQ_BITS'(head_item.ack_seq);
	assign can_send = (flight7 < FW7'(w)) &&
		(CMP_W'(next_seq_q) < CMP_W'(total_frames));
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		nx_state     = state_q;
		nx_next_seq  = next_seq_q;
		nx_oldest    = oldest_q;
		nx_in_flight = in_flight_q;
		nx_next_slot = next_slot_q;
		nx_old_slot  = old_slot_q;
		nx_stale     = stale_q || win_wr;
		nx_run_seq   = run_seq_q;
		nx_run_slot  = run_slot_q;
		nx_run_left  = run_left_q;
		nx_rem_n     = rem_n_q;
		nx_rem_o     = rem_o_q;
		nx_rem_rn    = rem_rn_q;
		nx_rem_ro    = rem_ro_q;
		nx_rem_cnt   = rem_cnt_q;
		pop          = 1'b0;
		out_load     = 1'b0;
		o_action     = gbn_pkg::ACT_IGNORE;
		o_seq        = '0;
		o_slot       = '0;
		o_last       = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (head_valid && stale_q) begin
					nx_state   = ST_REM;
					nx_rem_n   = next_seq_q;
					nx_rem_o   = oldest_q;
					nx_rem_rn  = '0;
					nx_rem_ro  = '0;
					nx_rem_cnt = CNT_W'(SEQ_BITS);
				end else if (head_valid && out_free) begin
					pop = 1'b1;
					case (head_item.op)
						gbn_pkg::OP_SEND: begin
							out_load = 1'b1;
							if (can_send) begin
								o_action     = gbn_pkg::ACT_SEND;
								o_seq        = next_seq_q;
								o_slot       = next_slot_q;
								nx_next_seq  = next_seq_q + 1'b1;
								nx_in_flight = in_flight_q + 1'b1;
								nx_next_slot = slot_inc(next_slot_q, w, &next_seq_q);
							end
						end
						gbn_pkg::OP_ACK: begin
							out_load = 1'b1;
							if (in_flight_q != '0 && ack_v == oldest_q) begin
								o_action     = gbn_pkg::ACT_ACK;
								o_seq        = ack_v;
								o_slot       = old_slot_q;
								nx_oldest    = oldest_q + 1'b1;
								nx_in_flight = in_flight_q - 1'b1;
								nx_old_slot  = slot_inc(old_slot_q, w, &oldest_q);
							end
						end
						gbn_pkg::OP_TIMEOUT: begin
							if (in_flight_q != '0) begin
								nx_state    = ST_RUN;
								nx_run_seq  = oldest_q;
								nx_run_slot = old_slot_q;
								nx_run_left = run_n;
							end else begin
								out_load = 1'b1;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_REM: begin
				nx_rem_n   = rem_n_q << 1;
				nx_rem_o   = rem_o_q << 1;
				nx_rem_rn  = rem_step(rem_rn_q, rem_n_q[SEQ_BITS-1], w);
				nx_rem_ro  = rem_step(rem_ro_q, rem_o_q[SEQ_BITS-1], w);
				nx_rem_cnt = rem_cnt_q - 1'b1;
				if (rem_cnt_q == CNT_W'(1)) begin
					nx_state     = ST_IDLE;
					nx_next_slot = nx_rem_rn;
					nx_old_slot  = nx_rem_ro;
					nx_stale     = 1'b0;
				end
			end
			ST_RUN: begin
				if (out_free) begin
					out_load    = 1'b1;
					o_action    = gbn_pkg::ACT_RESEND;
					o_seq       = run_seq_q;
					o_slot      = run_slot_q;
					o_last      = run_left_q == FW7'(1);
					nx_run_seq  = run_seq_q + 1'b1;
					nx_run_slot = slot_inc(run_slot_q, w, &run_seq_q);
					nx_run_left = run_left_q - 1'b1;
					if (o_last) begin
						nx_state = ST_IDLE;
					end
				end
			end
			default: begin
				nx_state = ST_IDLE;
			end
		endcase

		o_done = (nx_in_flight == '0) && (CMP_W'(nx_oldest) >= CMP_W'(total_frames));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_seq_q  <= '0;
			oldest_q    <= '0;
			in_flight_q <= '0;
			next_slot_q <= '0;
			old_slot_q  <= '0;
			stale_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= nx_state;
			next_seq_q  <= nx_next_seq;
			oldest_q    <= nx_oldest;
			in_flight_q <= nx_in_flight;
			next_slot_q <= nx_next_slot;
			old_slot_q  <= nx_old_slot;
			stale_q     <= nx_stale;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		run_seq_q  <= nx_run_seq;
		run_slot_q <= nx_run_slot;
		run_left_q <= nx_run_left;
		rem_n_q    <= nx_rem_n;
		rem_o_q    <= nx_rem_o;
		rem_rn_q   <= nx_rem_rn;
		rem_ro_q   <= nx_rem_ro;
		rem_cnt_q  <= nx_rem_cnt;
		if (out_load) begin
			out_action_q <= o_action;
			out_seq_q    <= gbn_pkg::fseq_t'(o_seq);
			out_slot_q   <= gbn_pkg::slot_t'(o_slot);
			out_done_q   <= o_done;
			out_last_q   <= o_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.action    = out_action_q;
	assign rsp.frame_seq = out_seq_q;
	assign rsp.slot      = out_slot_q;
	assign rsp.all_acked = out_done_q;
	assign rsp.last      = out_last_q;

endmodule

/* design/go_back_n_sender.sv */
// go_back_n_sender: send, ack and unused requests and a timeout with nothing outstanding
// give one result each; a timeout that finds frames outstanding holds the back end in a
// resend state and resends them, one result per cycle while the result channel is free.
// a result passes the front register, the queue and the output register; one send or ack per
// cycle while results are taken; after a window register write the next item waits while the
// serial remainder unit rebuilds the slot counters; reset: window 8, total 1, counters zero.
module go_back_n_sender #(
	parameter int WINDOW_MAX = 32,
	parameter int SEQ_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gbn_req_if.sink   req,
	gbn_rsp_if.source rsp,
	gbn_cfg_if.sink   cfg
);

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	logic [gbn_pkg::WSIZE_W-1:0] win_limit_q;
	logic [gbn_pkg::TOTAL_W-1:0] total_frames_q;
	logic                        cfg_wr;
	logic                        win_wr;

	// front to queue
	logic                        push_valid;
	logic                        push_ready;
	gbn_pkg::item_t              push_item;

	// queue to back
	logic                        head_valid;
	logic                        pop;
	gbn_pkg::item_t              head_item;

	// the config channel never stalls
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	// a new window invalidates the tracked slots
	assign win_wr    = cfg_wr && (cfg.index == gbn_pkg::REG_WIN_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_limit_q    <= gbn_pkg::WSIZE_W'(8);
			total_frames_q <= gbn_pkg::TOTAL_W'(1);
		end else if (cfg_wr) begin
			case (cfg.index)
				gbn_pkg::REG_WIN_LIMIT: begin
					win_limit_q <= cfg.data[gbn_pkg::WSIZE_W-1:0];
				end
				gbn_pkg::REG_TOTAL_FRAMES: begin
					total_frames_q <= cfg.data[gbn_pkg::TOTAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front end: registers each request transaction and decodes its kind
	gbn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// short queue so a timeout run in the back end does not stall the input at once
	gbn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head_valid (head_valid),
		.pop        (pop),
		.head_item  (head_item)
	);

	// back end: window state, slot counters, resend runs and the output register
	gbn_back #(
		.WINDOW_MAX (WINDOW_MAX),
		.SEQ_BITS   (SEQ_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.win_limit    (win_limit_q),
		.total_frames (total_frames_q),
		.win_wr       (win_wr),
		.rsp          (rsp)
	);

endmodule

/* bench/go_back_n_sender_checker.sv */
`timescale 1ns / 100ps
// go_back_n_sender_checker: watches the request, result and register channels of the
// go-back-n sender, predicts every result and compares it field by field; uses gbn_pkg
module go_back_n_sender_checker
	import gbn_pkg::*;
#(
	parameter int WINDOW_MAX = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  logic [KIND_W-1:0]    req_kind,
	input  fseq_t                req_ack_seq,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  logic [ACTION_W-1:0]  rsp_action,
	input  fseq_t                rsp_frame_seq,
	input  slot_t                rsp_slot,
	input  logic                 rsp_all_acked,
	input  logic                 rsp_last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   mismatches,
	output int                   awaited,
	output int                   checked,
	output int                   resends
);

	typedef struct packed {
		action_t action;
		fseq_t   frame_seq;
		slot_t   slot;
		logic    all_acked;
		logic    last;
	} outcome_t;

	logic [WSIZE_W-1:0] window_reg;
	logic [TOTAL_W-1:0] total_reg;
	fseq_t              next_seq;
	fseq_t              oldest_unacked;
	int                 in_flight;
	outcome_t           awaited_results[$];
	outcome_t           want;

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (got !== exp_val)
			flag_mismatch($sformatf("result %0d %s got %0h, want %0h", checked, name, got,
				exp_val));
	endtask

	// done flag is taken from the state after the update of this transaction
	task automatic expect_outcome(input action_t act, input fseq_t seq, input int slot_val,
		input logic is_last);
		outcome_t o;
		o.action    = act;
		o.frame_seq = seq;
		o.slot      = slot_t'(slot_val);
		o.all_acked = (in_flight == 0 && oldest_unacked >= total_reg);
		o.last      = is_last;
		awaited_results.push_back(o);
	endtask

	task automatic predict_transfer(input kind_t k, input fseq_t ack);
		int    w;
		int    n;
		bit    taken;
		fseq_t s;
		// window register saturates to 1..WINDOW_MAX
		w = (window_reg == 0) ? 1 : ((window_reg > WINDOW_MAX) ? WINDOW_MAX : int'(window_reg));
		taken = 1'b0;
		case (k)
			KIND_SEND: begin
				if (in_flight < w && next_seq < total_reg) begin
					s = next_seq;
					next_seq = next_seq + 1'b1;
					in_flight++;
					expect_outcome(ACT_SEND, s, s % w, 1'b1);
					taken = 1'b1;
				end
			end
			KIND_ACK: begin
				if (in_flight > 0 && ack == oldest_unacked) begin
					oldest_unacked = oldest_unacked + 1'b1;
					in_flight--;
					expect_outcome(ACT_ACK, ack, ack % w, 1'b1);
					taken = 1'b1;
				end
			end
			KIND_TIMEOUT: begin
				if (in_flight > 0) begin
					n = (in_flight > WINDOW_MAX) ? WINDOW_MAX : in_flight;
					for (int i = 0; i < n; i++) begin
						s = oldest_unacked + fseq_t'(i);
						expect_outcome(ACT_RESEND, s, s % w, i == n - 1);
					end
					taken = 1'b1;
				end
			end
			default: ;
		endcase
		if (!taken)
			expect_outcome(ACT_IGNORE, '0, 0, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_reg     = 6'd8;
			total_reg      = 16'd1;
			next_seq       = '0;
			oldest_unacked = '0;
			in_flight      = 0;
			awaited_results.delete();
			mismatches     = 0;
			awaited        = 0;
			checked        = 0;
			resends        = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_WIN_LIMIT:    window_reg = cfg_data[WSIZE_W-1:0];
					REG_TOTAL_FRAMES: total_reg = cfg_data[TOTAL_W-1:0];
					default: ;
				endcase
			end
			// results of a transaction never come out on the edge that takes it
			if (rsp_valid && rsp_ready) begin
				checked++;
				if (awaited_results.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with nothing pending", checked));
				end else begin
					want = awaited_results.pop_front();
					if (want.action == ACT_RESEND)
						resends++;
					compare_field("action", rsp_action, want.action);
					compare_field("frame_seq", rsp_frame_seq, want.frame_seq);
					compare_field("slot", rsp_slot, want.slot);
					compare_field("all_acked", rsp_all_acked, want.all_acked);
					compare_field("last", rsp_last, want.last);
				end
			end
			if (req_valid && req_ready)
				predict_transfer(kind_t'(req_kind), req_ack_seq);
			awaited = awaited_results.size();
		end
	end

endmodule

/* bench/go_back_n_sender_test.sv */
`timescale 1ns / 100ps
// go_back_n_sender_test: drives send, ack and timeout transactions and register writes
// into go_back_n_sender and gives the verdict; uses gbn_pkg, gbn_if and the checker
module go_back_n_sender_test;
	import gbn_pkg::*;

	localparam int WINDOW_MAX      = 32;
	localparam int SEQ_BITS        = 16;
	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 6;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 36;
	localparam int PRESSURE_PHASE  = 2;
	localparam int HOLD_OFF_CYCLES = 150;
	// a window write leads to a slot rebuild, and results trail behind their requests
	localparam int SETTLE_CYCLES   = 8;
	// longest legal silence is the hold-off plus a rebuild and a long gap
	localparam int STALL_LIMIT     = 1000;

	logic clk = 1'b0;
	logic arst_n;

	int mismatches;
	int awaited;
	int checked;
	int resends;
	int sent_items;
	int settings;
	int idle_cycles = 0;

	// quiet: no idling on either side; pressure: mostly sends behind a held receiver
	bit quiet;
	bit pressure;
	bit hold_off_req;

	// rough view of the window, only to steer acks toward the oldest frame
	logic [WSIZE_W-1:0] shadow_window;
	fseq_t              shadow_total;
	fseq_t              shadow_next;
	fseq_t              shadow_oldest;
	int                 shadow_flight;

	gbn_req_if req();
	gbn_rsp_if rsp();
	gbn_cfg_if cfg();

	go_back_n_sender #(
		.WINDOW_MAX(WINDOW_MAX),
		.SEQ_BITS  (SEQ_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	go_back_n_sender_checker #(
		.WINDOW_MAX(WINDOW_MAX)
	) result_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_ready    (req.ready),
		.req_kind     (req.kind),
		.req_ack_seq  (req.ack_seq),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.rsp_action   (rsp.action),
		.rsp_frame_seq(rsp.frame_seq),
		.rsp_slot     (rsp.slot),
		.rsp_all_acked(rsp.all_acked),
		.rsp_last     (rsp.last),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.mismatches   (mismatches),
		.awaited      (awaited),
		.checked      (checked),
		.resends      (resends)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// mostly back to back, sometimes a few cycles, now and then a long pause
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	task automatic sender_pause();
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// present one request transaction and hold it until taken; valid is left high
	task automatic offer(input kind_t k, input fseq_t a);
		int w;
		req.valid   <= 1'b1;
		req.kind    <= k;
		req.ack_seq <= a;
		do @(posedge clk); while (!req.ready);
		sent_items++;
		w = (shadow_window == 0) ? 1 :
			((shadow_window > WINDOW_MAX) ? WINDOW_MAX : int'(shadow_window));
		case (k)
			KIND_SEND: begin
				if (shadow_flight < w && shadow_next < shadow_total) begin
					shadow_next = shadow_next + 1'b1;
					shadow_flight++;
				end
			end
			KIND_ACK: begin
				if (shadow_flight > 0 && a == shadow_oldest) begin
					shadow_oldest = shadow_oldest + 1'b1;
					shadow_flight--;
				end
			end
			default: ;
		endcase
	endtask

	// register transaction; valid stays high so writes can go back to back
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// stop offering, let every pending result come out, then a few spare cycles
	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (awaited != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [WSIZE_W-1:0] win, input fseq_t tot,
		input bit set_total);
		drain();
		write_reg(REG_WIN_LIMIT, CFG_DAT_W'(win));
		shadow_window = win;
		if (set_total) begin
			write_reg(REG_TOTAL_FRAMES, tot);
			shadow_total = tot;
		end
		cfg.valid <= 1'b0;
		settings++;
	endtask

	// stimulus: reset, directed corner cases, then random phases
	initial begin
		logic [WSIZE_W-1:0] win;
		fseq_t              tot;
		bit                 set_total;
		int                 r;
		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.kind      <= KIND_SEND;
		req.ack_seq   <= '0;
		cfg.valid     <= 1'b0;
		cfg.index     <= REG_WIN_LIMIT;
		cfg.data      <= '0;
		shadow_window = 6'd8;
		shadow_total  = 16'd1;
		shadow_next   = '0;
		shadow_oldest = '0;
		shadow_flight = 0;
		settings      = 1;
		sent_items    = 0;
		quiet         = 1'b0;
		pressure      = 1'b0;
		hold_off_req  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window 8, a one-frame transfer
		offer(KIND_TIMEOUT, 16'h0000);   // nothing in flight, ignored
		offer(KIND_ACK, 16'h0000);       // ack with nothing in flight
		offer(KIND_UNUSED, 16'hFFFF);    // unused kind
		offer(KIND_SEND, 16'h5555);      // frame 0
		offer(KIND_SEND, 16'hAAAA);      // transfer exhausted, refused
		offer(KIND_ACK, 16'hFFFF);       // wrong sequence, ignored
		offer(KIND_TIMEOUT, 16'h0000);   // resend of frame 0 alone
		offer(KIND_ACK, 16'h0000);       // last frame acked, transfer done
		offer(KIND_SEND, 16'h0000);      // refused after completion

		// window register zero behaves as a window of one
		reconfigure(6'd0, 16'hFFFF, 1'b1);
		offer(KIND_SEND, 16'h0000);      // frame 1
		offer(KIND_SEND, 16'h0000);      // window full, refused
		offer(KIND_ACK, 16'h0002);       // ack ahead of the oldest, ignored
		offer(KIND_TIMEOUT, 16'h0000);
		offer(KIND_ACK, 16'h0001);

		// oversized window register, empty transfer
		reconfigure(6'd63, 16'h0000, 1'b1);
		offer(KIND_SEND, 16'h0000);      // zero frames, refused
		offer(KIND_UNUSED, 16'h5555);

		// a burst in flight, then the window shrinks under it
		reconfigure(6'd63, 16'hFFFF, 1'b1);
		repeat (5) offer(KIND_SEND, 16'h0000);
		offer(KIND_TIMEOUT, 16'hFFFF);
		reconfigure(6'd2, 16'h0000, 1'b0);
		offer(KIND_SEND, 16'h0000);      // in flight above the window, refused
		offer(KIND_TIMEOUT, 16'h0000);   // still resends all five
		offer(KIND_ACK, 16'h0002);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pressure = (phase == PRESSURE_PHASE);
			quiet    = !pressure && (phase % 3 == 1);
			if (pressure) begin
				win       = 6'd32;
				tot       = 16'hFFFF;
				set_total = 1'b1;
			end else begin
				case ($urandom_range(0, 5))
					0:       win = 6'd0;
					1:       win = 6'd1;
					2:       win = 6'd63;
					3:       win = 6'd32;
					default: win = WSIZE_W'($urandom_range(0, 63));
				endcase
				case ($urandom_range(0, 9))
					0:       tot = 16'h0000;
					1:       tot = shadow_next;
					2:       tot = 16'hFFFF;
					default: tot = shadow_next + fseq_t'($urandom_range(1, 60));
				endcase
				set_total = (phase == 0) || ($urandom_range(0, 3) != 0);
			end
			reconfigure(win, tot, set_total);
			// receiver goes quiet while sends keep coming, so the block backs up
			if (pressure)
				hold_off_req = 1'b1;

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				sender_pause();
				r = $urandom_range(0, 99);
				if (r < (pressure ? 80 : 40))
					offer(KIND_SEND, fseq_t'($urandom));
				else if (r < (pressure ? 95 : 70))
					offer(KIND_ACK, shadow_oldest);
				else if (pressure || r < 78)
					offer(KIND_TIMEOUT, fseq_t'($urandom));
				else if (r < 86)
					offer(KIND_ACK, fseq_t'($urandom));
				else if (r < 93)
					offer(KIND_ACK, shadow_oldest + fseq_t'($urandom_range(1, 3)));
				else
					offer(KIND_UNUSED, fseq_t'($urandom));
			end
		end

		drain();
		$display("ran %0d request transactions over %0d register settings", sent_items,
			settings);
		$display("checked %0d results, %0d of them resends", checked, resends);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side: random back-pressure, plus the long hold-off when asked
	initial begin
		int idle_left;
		idle_left = 0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				idle_left    = HOLD_OFF_CYCLES;
			end
			if (idle_left > 0) begin
				rsp.ready <= 1'b0;
				idle_left--;
			end else begin
				rsp.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 2) == 0)
					idle_left = pick_gap();
			end
		end
	end

	// watchdog on cycles without any transaction on any channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results still pending", idle_cycles,
				awaited);
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
